// File: src/spsh_pkg.sv
// Package: widths, constants and derived sizes for the sphere point sampler.
package spsh_pkg;

    // Fixed sizes of the block
    localparam int GRID_SIZE  = 20;
    localparam int FRAC_BITS  = 16;
    localparam int COUNT_BITS = 32;

    // Field widths of the transfer payloads
    localparam int U_W     = 16;
    localparam int IDX_W   = 5;
    localparam int OUT_W   = FRAC_BITS + 2;

    // Arithmetic widths
    localparam int MUL_W   = FRAC_BITS + 2;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int R2_W    = 2 * FRAC_BITS + 2;
    localparam int SQ_W    = R2_W + 1;
    localparam int ROOT_W  = FRAC_BITS + 1;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W   = $clog2(SQRT_STEPS);

    // Histogram sizes
    localparam int CELLS   = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int BIN_W   = $clog2(GRID_SIZE);
    localparam int GRID_W  = $clog2(GRID_SIZE + 1);
    localparam int OFF_W   = OUT_W;

    // Constants in the working formats
    localparam logic [R2_W-1:0]          ONE2     = R2_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [MUL_W-1:0]  OPND_ONE = MUL_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] P_ONE    = PROD_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] P_MONE   = -(PROD_W'(1) << FRAC_BITS);
    localparam logic [OFF_W-1:0]         OFF_ONE  = OFF_W'(1) << FRAC_BITS;
    localparam logic [COUNT_BITS-1:0]    COUNT_MAX = '1;

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

endpackage

// File: src/spsh_if.sv
// Interfaces: request and result channels of the sphere point sampler.
interface spsh_req_if;
    import spsh_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [U_W-1:0]   u_in;
    logic [U_W-1:0]   v_in;
    logic [IDX_W-1:0] bin_row;
    logic [IDX_W-1:0] bin_col;

    modport source (output valid, req_type, u_in, v_in, bin_row, bin_col, input ready);
    modport sink   (input valid, req_type, u_in, v_in, bin_row, bin_col, output ready);
endinterface

interface spsh_res_if;
    import spsh_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic signed [OUT_W-1:0] z_out;
    logic [COUNT_BITS-1:0]  bin_count;

    modport source (output valid, accepted, x_out, y_out, z_out, bin_count, input ready);
    modport sink   (input valid, accepted, x_out, y_out, z_out, bin_count, output ready);
endinterface

// File: src/spsh_ram.sv
// Generic single write port, single read port RAM with registered read data.
module spsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 400,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sphere_point_sampler_histogram_core.sv
// Top level: Marsaglia sphere point sampler with an XY bin histogram in RAM.
// Sample: request transfer, squares of s and t, sum, disc check, square root
// iteration, x and y products, result forming, binning and a bin increment,
// then hand-over; a rejected pair ends after the check, a bin read after a RAM
// read, a read outside the grid at once. One request at a time: a new
// request is taken only once the previous result is in the output register.
// After reset a clearing pass zeroes all 400 bins; no request is taken in it.
module sphere_point_sampler_histogram_core
    import spsh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    spsh_req_if.sink   i_req,
    spsh_res_if.source o_res
);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_ISSUE, ST_RD_TAKE,
        ST_SQ_S, ST_SQ_T, ST_SUM, ST_CHECK, ST_SQRT,
        ST_MUL_X, ST_MUL_Y, ST_FORM, ST_BIN, ST_ADDR,
        ST_RMW_RD, ST_RMW_WR, ST_DONE
    } t_state;

    // floor to Q.FRAC_BITS, then saturate to -1..+1
    function automatic logic signed [OUT_W-1:0] to_q(input logic signed [PROD_W-1:0] full);
        logic signed [PROD_W-1:0] sh;
        logic signed [PROD_W-1:0] sat;
        sh = full >>> FRAC_BITS;
        if (sh > P_ONE) begin
            sat = P_ONE;
        end else if (sh < P_MONE) begin
            sat = P_MONE;
        end else begin
            sat = sh;
        end
        return sat[OUT_W-1:0];
    endfunction

    // bin index floor(GRID_SIZE*(c+1)/2), top edge clamped
    function automatic logic [BIN_W-1:0] bin_of(input logic signed [OUT_W-1:0] c);
        logic [OFF_W-1:0]        off;
        logic [OFF_W+GRID_W-1:0] sc;
        logic [GRID_W-1:0]       b;
        off = OFF_W'(unsigned'(c)) + OFF_ONE;
        sc  = (OFF_W+GRID_W)'(off) * (OFF_W+GRID_W)'(GRID_SIZE);
        b   = GRID_W'(sc >> (FRAC_BITS + 1));
        if (b > GRID_W'(GRID_SIZE - 1)) begin
            b = GRID_W'(GRID_SIZE - 1);
        end
        return b[BIN_W-1:0];
    endfunction

    t_state                   r_state;
    logic [ADDR_W-1:0]        r_clr;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [MUL_W-1:0]  r_s;
    logic signed [MUL_W-1:0]  r_t;
    logic signed [PROD_W-1:0] r_prod;
    logic [R2_W-1:0]          r_r2;
    logic [SQ_W-1:0]          r_w;
    logic [SQ_W-1:0]          r_root;
    logic [SQ_W-1:0]          r_bit;
    logic [CNT_W-1:0]         r_step;
    logic [BIN_W-1:0]         r_bx;
    logic [BIN_W-1:0]         r_by;

    // staged result
    logic                     r_acc;
    logic signed [OUT_W-1:0]  r_x;
    logic signed [OUT_W-1:0]  r_y;
    logic signed [OUT_W-1:0]  r_z;
    logic [COUNT_BITS-1:0]    r_cnt;

    // output register
    logic                     r_ovalid;
    logic                     r_oacc;
    logic signed [OUT_W-1:0]  r_ox;
    logic signed [OUT_W-1:0]  r_oy;
    logic signed [OUT_W-1:0]  r_oz;
    logic [COUNT_BITS-1:0]    r_ocnt;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] product;
    logic [SQ_W-1:0]          sq_sum;
    logic                     sq_ge;
    logic signed [PROD_W-1:0] z_full;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [COUNT_BITS-1:0]    ram_wdata;
    logic [COUNT_BITS-1:0]    ram_rdata;
    logic                     req_xfer;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // shared multiplier operand selection
    always_comb begin
        unique case (r_state)
            ST_SQ_S:  begin mul_a = r_s; mul_b = r_s; end
            ST_SQ_T:  begin mul_a = r_t; mul_b = r_t; end
            ST_MUL_X: begin mul_a = r_s; mul_b = signed'({1'b0, r_root[ROOT_W-1:0]}); end
            ST_MUL_Y: begin mul_a = r_t; mul_b = signed'({1'b0, r_root[ROOT_W-1:0]}); end
            default:  begin mul_a = r_s; mul_b = r_t; end
        endcase
    end

    assign product = mul_a * mul_b;

    // one square root step: trial subtract of root plus bit
    assign sq_sum = r_root + r_bit;
    assign sq_ge  = (r_w >= sq_sum);

    // z = 1 - 2*r2 in Q.2*FRAC_BITS
    assign z_full = signed'(PROD_W'(ONE2)) - signed'({1'b0, r_r2, 1'b0});

    // histogram write port: clearing pass or saturating increment
    always_comb begin
        ram_we    = (r_state == ST_CLEAR) || (r_state == ST_RMW_WR);
        ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_addr;
        if (r_state == ST_CLEAR) begin
            ram_wdata = '0;
        end else if (ram_rdata == COUNT_MAX) begin
            ram_wdata = ram_rdata;
        end else begin
            ram_wdata = ram_rdata + COUNT_BITS'(1);
        end
    end

    spsh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // ST_DONE reloads the output register itself
            if (r_ovalid && o_res.ready && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (r_clr == ADDR_W'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (req_xfer) begin
                        r_acc <= 1'b0;
                        r_x   <= '0;
                        r_y   <= '0;
                        r_z   <= '0;
                        r_cnt <= '0;
                        r_s   <= signed'({1'b0, i_req.u_in, 1'b0}) - OPND_ONE;
                        r_t   <= signed'({1'b0, i_req.v_in, 1'b0}) - OPND_ONE;
                        r_addr <= ADDR_W'(i_req.bin_row) * ADDR_W'(GRID_SIZE)
                                + ADDR_W'(i_req.bin_col);
                        if (i_req.req_type == REQ_SAMPLE) begin
                            r_state <= ST_SQ_S;
                        end else if (i_req.bin_row < IDX_W'(GRID_SIZE)
                                  && i_req.bin_col < IDX_W'(GRID_SIZE)) begin
                            r_state <= ST_RD_ISSUE;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_RD_ISSUE: begin
                    r_state <= ST_RD_TAKE;
                end
                ST_RD_TAKE: begin
                    r_cnt   <= ram_rdata;
                    r_state <= ST_DONE;
                end
                ST_SQ_S: begin
                    r_prod  <= product;
                    r_state <= ST_SQ_T;
                end
                ST_SQ_T: begin
                    r_r2    <= r_prod[R2_W-1:0];
                    r_prod  <= product;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_r2    <= r_r2 + r_prod[R2_W-1:0];
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_w    <= SQ_W'(ONE2 - r_r2);
                    r_root <= '0;
                    r_bit  <= SQ_W'(ONE2);
                    r_step <= '0;
                    if (r_r2 > ONE2) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        r_w    <= r_w - sq_sum;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == CNT_W'(SQRT_STEPS - 1)) begin
                        r_state <= ST_MUL_X;
                    end
                end
                ST_MUL_X: begin
                    r_prod  <= product;
                    r_state <= ST_MUL_Y;
                end
                ST_MUL_Y: begin
                    r_x     <= to_q(r_prod <<< 1);
                    r_prod  <= product;
                    r_state <= ST_FORM;
                end
                ST_FORM: begin
                    r_y     <= to_q(r_prod <<< 1);
                    r_z     <= to_q(z_full);
                    r_state <= ST_BIN;
                end
                ST_BIN: begin
                    r_bx    <= bin_of(r_x);
                    r_by    <= bin_of(r_y);
                    r_state <= ST_ADDR;
                end
                ST_ADDR: begin
                    r_addr  <= ADDR_W'(r_bx) * ADDR_W'(GRID_SIZE) + ADDR_W'(r_by);
                    r_state <= ST_RMW_RD;
                end
                ST_RMW_RD: begin
                    r_state <= ST_RMW_WR;
                end
                ST_RMW_WR: begin
                    r_acc   <= 1'b1;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // hand over once the output register is free
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_oacc   <= r_acc;
                        r_ox     <= r_x;
                        r_oy     <= r_y;
                        r_oz     <= r_z;
                        r_ocnt   <= r_cnt;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid     = r_ovalid;
    assign o_res.accepted  = r_oacc;
    assign o_res.x_out     = r_ox;
    assign o_res.y_out     = r_oy;
    assign o_res.z_out     = r_oz;
    assign o_res.bin_count = r_ocnt;

endmodule
